### rtl/core/arpr_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and defaults of the arp responder
package arpr_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 48;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_LOCAL_IP   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PREFIX_LEN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LOCAL_MAC  = 2'd2;

    localparam logic [5:0]  PREFIX_LEN_RST = 6'd24;

    // transaction kinds
    localparam logic [1:0] MODE_PACKET = 2'd0;
    localparam logic [1:0] MODE_FLUSH  = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] OP_REQUEST  = 16'h0001;
    localparam logic [15:0] OP_REPLY    = 16'h0002;

    localparam logic [2:0] VERDICT_REPLY_SENT  = 3'd0;
    localparam logic [2:0] VERDICT_NOT_ETH     = 3'd1;
    localparam logic [2:0] VERDICT_NOT_IPV4    = 3'd2;
    localparam logic [2:0] VERDICT_SENDER_OFF  = 3'd3;
    localparam logic [2:0] VERDICT_TARGET_OFF  = 3'd4;
    localparam logic [2:0] VERDICT_SENDER_LOC  = 3'd5;
    localparam logic [2:0] VERDICT_REPLY_RCVD  = 3'd6;
    localparam logic [2:0] VERDICT_NOT_REQUEST = 3'd7;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;

    typedef struct packed {
        logic [1:0]       mode;
        logic [15:0]      hw_type;
        logic [15:0]      proto_type;
        logic [15:0]      arp_op;
        logic [MAC_W-1:0] frame_dst_mac;
        logic [MAC_W-1:0] frame_src_mac;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  sender_ip;
        logic [IP_W-1:0]  target_ip;
    } req_t;

    typedef struct packed {
        logic [2:0]       verdict;
        logic [MAC_W-1:0] reply_dst_mac;
        logic [MAC_W-1:0] reply_target_mac;
        logic [IP_W-1:0]  reply_target_ip;
        logic             learned;
        logic             table_full;
        logic             lookup_hit;
        logic [MAC_W-1:0] lookup_mac;
    } rsp_t;

endpackage

### rtl/core/arpr_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for requests and results
interface arpr_req_if;
    logic          valid;
    logic          ready;
    arpr_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface arpr_rsp_if;
    logic          valid;
    logic          ready;
    arpr_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/arpr_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module arpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/arp_responder_with_learning.sv
`timescale 1ns / 1ps
// arp responder with learning: packet checks, binding table and lookup
//
// usage: one transaction on req is an arp packet's header fields, a flush of
// the binding table or a lookup of target_ip; each gives exactly one
// transaction on rsp. configuration is written on cfg_we / cfg_addr /
// cfg_data while the block is idle; local_mac is taken but the reply's
// sender fields are filled in by the transmit path.
// bindings sit in a ram; the valid entries are always the lowest ones, so
// a fill count marks them and a flush only clears the count.
// a packet that learns nothing, a flush or a mode 3 transaction goes from
// acceptance straight to S_OUT and from there to the output register.
// a lookup or a learning packet first walks the table in S_SCAN with one
// shared 32-bit ip comparator, one entry a cycle, behind the ram's
// registered read. one transaction is in work at a time; req is ready
// again once the result sits in the output register.
// a stalled rsp holds its result; the next request may be worked on
// meanwhile and then waits for the output register to free up.
// reset empties the table and sets local_ip 0, prefix_len 24; no clearing
// pass is needed, the block is ready right after reset.
module arp_responder_with_learning #(
    parameter int TABLE_ENTRIES = arpr_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    arpr_req_if.sink                        req,
    arpr_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [arpr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [arpr_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int ENT_W  = arpr_pkg::IP_W + arpr_pkg::MAC_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            fill_reg, fill_next;
    logic [CNT_W-1:0]            scan_reg, scan_next;
    logic                        rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]            hit_idx_reg, hit_idx_next;
    logic                        lookup_reg, lookup_next;
    logic [arpr_pkg::IP_W-1:0]   key_reg, key_next;
    logic [arpr_pkg::MAC_W-1:0]  mac_reg, mac_next;
    arpr_pkg::rsp_t              res_reg, res_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    arpr_pkg::rsp_t              rsp_data_reg, rsp_data_next;
    logic [arpr_pkg::IP_W-1:0]   local_ip_reg;
    logic [5:0]                  prefix_reg;

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [ENT_W-1:0]            ram_wdata;
    logic [ENT_W-1:0]            ram_rdata;
    logic [arpr_pkg::IP_W-1:0]   rd_ip;
    logic [arpr_pkg::MAC_W-1:0]  rd_mac;

    logic [arpr_pkg::IP_W-1:0]   mask;
    logic                        target_in, sender_in;
    logic [2:0]                  pre_verdict;
    logic                        is_req, unicast, want_learn, answer;

    arpr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_ip  = ram_rdata[ENT_W-1 -: arpr_pkg::IP_W];
    assign rd_mac = ram_rdata[arpr_pkg::MAC_W-1:0];

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // prefix lengths of 32 and above shift every bit out, giving a full mask
    assign mask      = ~({arpr_pkg::IP_W{1'b1}} >> prefix_reg);
    assign target_in = ((req.data.target_ip ^ local_ip_reg) & mask) == '0;
    assign sender_in = ((req.data.sender_ip ^ local_ip_reg) & mask) == '0;
    assign is_req    = (req.data.arp_op == arpr_pkg::OP_REQUEST);
    assign unicast   = !req.data.frame_dst_mac[40];
    assign want_learn = unicast || is_req;
    assign answer    = is_req && (req.data.target_ip == local_ip_reg);

    always_comb
    begin
        if (req.data.proto_type != arpr_pkg::PROTO_IPV4)
            pre_verdict = arpr_pkg::VERDICT_NOT_IPV4;
        else if (req.data.hw_type != arpr_pkg::HW_ETHERNET)
            pre_verdict = arpr_pkg::VERDICT_NOT_ETH;
        else if (!target_in)
            pre_verdict = arpr_pkg::VERDICT_TARGET_OFF;
        else if (!sender_in)
            pre_verdict = arpr_pkg::VERDICT_SENDER_OFF;
        else if (req.data.sender_ip == local_ip_reg)
            pre_verdict = arpr_pkg::VERDICT_SENDER_LOC;
        else
            pre_verdict = arpr_pkg::VERDICT_REPLY_SENT;
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        scan_next      = scan_reg;
        rd_vld_next    = 1'b0;
        hit_idx_next   = hit_idx_reg;
        lookup_next    = lookup_reg;
        key_next       = key_reg;
        mac_next       = mac_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = hit_idx_reg;
        ram_wdata      = {key_reg, mac_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_next    = '0;
                    scan_next   = '0;
                    lookup_next = (req.data.mode == arpr_pkg::MODE_LOOKUP);
                    key_next    = (req.data.mode == arpr_pkg::MODE_LOOKUP) ?
                                  req.data.target_ip : req.data.sender_ip;
                    mac_next    = req.data.sender_mac;
                    state_next  = S_OUT;
                    case (req.data.mode)
                        arpr_pkg::MODE_FLUSH:
                        begin
                            fill_next = '0;
                        end
                        arpr_pkg::MODE_LOOKUP:
                        begin
                            state_next = S_SCAN;
                        end
                        arpr_pkg::MODE_PACKET:
                        begin
                            res_next.verdict = pre_verdict;
                            if (pre_verdict == arpr_pkg::VERDICT_REPLY_SENT)
                            begin
                                if (answer)
                                begin
                                    res_next.reply_dst_mac    = req.data.frame_src_mac;
                                    res_next.reply_target_mac = req.data.sender_mac;
                                    res_next.reply_target_ip  = req.data.sender_ip;
                                end
                                else if (req.data.arp_op == arpr_pkg::OP_REPLY)
                                begin
                                    res_next.verdict = arpr_pkg::VERDICT_REPLY_RCVD;
                                end
                                else
                                begin
                                    res_next.verdict = arpr_pkg::VERDICT_NOT_REQUEST;
                                end
                                if (want_learn)
                                begin
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rd_vld_reg && (rd_ip == key_reg))
                begin
                    if (lookup_reg)
                    begin
                        res_next.lookup_hit = 1'b1;
                        res_next.lookup_mac = rd_mac;
                    end
                    else
                    begin
                        // known sender: refresh its mac in place
                        ram_we           = 1'b1;
                        ram_waddr        = hit_idx_reg;
                        res_next.learned = 1'b1;
                    end
                    state_next = S_OUT;
                end
                else if (scan_reg < fill_reg)
                begin
                    rd_vld_next  = 1'b1;
                    hit_idx_next = scan_reg[IDX_W-1:0];
                    scan_next    = scan_reg + CNT_W'(1);
                end
                else if (!rd_vld_reg)
                begin
                    if (!lookup_reg)
                    begin
                        if (fill_reg != FULL_CNT)
                        begin
                            ram_we           = 1'b1;
                            ram_waddr        = fill_reg[IDX_W-1:0];
                            fill_next        = fill_reg + CNT_W'(1);
                            res_next.learned = 1'b1;
                        end
                        else
                        begin
                            res_next.table_full = 1'b1;
                        end
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            scan_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            local_ip_reg  <= '0;
            prefix_reg    <= arpr_pkg::PREFIX_LEN_RST;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            scan_reg      <= scan_next;
            rd_vld_reg    <= rd_vld_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    arpr_pkg::REG_LOCAL_IP:   local_ip_reg <= cfg_data[arpr_pkg::IP_W-1:0];
                    arpr_pkg::REG_PREFIX_LEN: prefix_reg   <= cfg_data[5:0];
                    arpr_pkg::REG_LOCAL_MAC:  ;
                    default:                  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        lookup_reg   <= lookup_next;
        key_reg      <= key_next;
        mac_reg      <= mac_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule

### rtl/core/arpr_checker.sv
`timescale 1ns / 1ps
// port-level checks of the arp responder, bound to the top level
module arpr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input arpr_pkg::rsp_t rsp_data
);

    // a result waiting on the receiver stays put
    ap_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("rsp changed while stalled");

    // one transaction in work at a time
    ap_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    ap_learn_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_data.learned && rsp_data.table_full))
        else $error("learned and table_full both set");

    ap_reply_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.verdict != arpr_pkg::VERDICT_REPLY_SENT) |->
        (rsp_data.reply_dst_mac == '0) && (rsp_data.reply_target_mac == '0) &&
        (rsp_data.reply_target_ip == '0))
        else $error("reply fields set without a reply");

    ap_lookup_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.lookup_hit |-> rsp_data.lookup_mac == '0)
        else $error("lookup mac set on a miss");

endmodule

bind arp_responder_with_learning arpr_checker u_arpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
